/* rtl/prqd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package prqd_pkg;

  localparam int NUM_LEVELS = 32;
  localparam int NUM_TASKS  = 64;

  localparam int LVL_W  = 5;
  localparam int TASK_W = 6;
  localparam int CNT_W  = TASK_W + 1;
  localparam int LIM_W  = LVL_W + 1;

  localparam logic [1:0] MODE_ENQUEUE     = 2'd0;
  localparam logic [1:0] MODE_PICK_HIGHER = 2'd1;
  localparam logic [1:0] MODE_PICK_SAME   = 2'd2;
  localparam logic [1:0] MODE_PEND_RUN    = 2'd3;

  localparam logic [1:0] ST_DISPATCHED = 2'd0;
  localparam logic [1:0] ST_NONE       = 2'd1;
  localparam logic [1:0] ST_ENQUEUED   = 2'd2;
  localparam logic [1:0] ST_REJECTED   = 2'd3;

  typedef struct packed {
    logic capture;
    logic look;
    logic enq;
    logic pop;
    logic fix_head;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic enq;
    logic reject;
    logic hit;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/prqd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module prqd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire prqd_pkg::stat_t stat,
  output prqd_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_HEAD = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;
  logic       out_free;
  logic       do_pop;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign do_pop   = !stat.enq && stat.hit && !stat.reject;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_LOOK;
      end
      S_LOOK: state_next = S_ACT;
      S_ACT: begin
        state_next = do_pop ? S_HEAD : S_FIN;
      end
      S_HEAD: state_next = S_FIN;
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.capture  = accept;
    cmd.look     = (state == S_LOOK);
    cmd.enq      = (state == S_ACT) && stat.enq && !stat.reject;
    cmd.pop      = (state == S_ACT) && do_pop;
    cmd.fix_head = (state == S_HEAD);
    cmd.load_out = (state == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.load_out || (out_valid && out_stall);
    end
  end

endmodule

`default_nettype wire

/* rtl/prqd_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module prqd_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire prqd_pkg::cmd_t                cmd,
  output prqd_pkg::stat_t                    stat,
  input  wire logic [1:0]                    mode,
  input  wire logic [prqd_pkg::TASK_W-1:0]   task_id,
  input  wire logic [prqd_pkg::LVL_W-1:0]    task_priority,
  input  wire logic                          current_valid,
  input  wire logic [prqd_pkg::LVL_W-1:0]    current_priority,
  output logic [1:0]                         status,
  output logic [prqd_pkg::TASK_W-1:0]        picked_task,
  output logic [prqd_pkg::LVL_W-1:0]         picked_priority,
  output logic                               switch_request
);

  logic [1:0]                      mode_q;
  logic [prqd_pkg::TASK_W-1:0]     tid_q;
  logic [prqd_pkg::LVL_W-1:0]      tprio_q;
  logic                            cv_q;
  logic [prqd_pkg::LVL_W-1:0]      cp_q;

  logic [prqd_pkg::CNT_W-1:0]      level_count [prqd_pkg::NUM_LEVELS];
  logic [prqd_pkg::CNT_W-1:0]      total_queued;
  logic [prqd_pkg::NUM_LEVELS-1:0] nonempty;

  logic [prqd_pkg::TASK_W-1:0]     head_mem [prqd_pkg::NUM_LEVELS];
  logic [prqd_pkg::TASK_W-1:0]     tail_mem [prqd_pkg::NUM_LEVELS];
  logic [prqd_pkg::TASK_W-1:0]     link_mem [prqd_pkg::NUM_TASKS];

  logic [prqd_pkg::TASK_W-1:0]     head_rd;
  logic [prqd_pkg::TASK_W-1:0]     tail_rd;
  logic [prqd_pkg::TASK_W-1:0]     link_rd;

  logic [prqd_pkg::LVL_W-1:0]      lvl_q;
  logic                            enq_q;
  logic                            rej_q;
  logic                            hit_q;

  logic [prqd_pkg::LIM_W-1:0]      scan_limit;
  logic [prqd_pkg::NUM_LEVELS-1:0] eligible;
  logic [prqd_pkg::LVL_W-1:0]      scan_lvl;
  logic                            scan_hit;
  logic [prqd_pkg::LVL_W-1:0]      lvl_sel;
  logic                            rej_sel;
  logic                            hit_sel;
  logic                            same_ok;
  logic                            dispatched;

  logic                            head_we;
  logic [prqd_pkg::TASK_W-1:0]     head_wd;

  always_comb begin
    for (int i = 0; i < prqd_pkg::NUM_LEVELS; i++) begin
      nonempty[i] = (level_count[i] != '0);
    end
  end

  always_comb begin
    if (mode_q == prqd_pkg::MODE_PICK_HIGHER && cv_q) begin
      scan_limit = {1'b0, cp_q};
    end else begin
      scan_limit = prqd_pkg::LIM_W'(prqd_pkg::NUM_LEVELS);
    end
    for (int i = 0; i < prqd_pkg::NUM_LEVELS; i++) begin
      eligible[i] = nonempty[i] && (prqd_pkg::LIM_W'(i) < scan_limit);
    end
  end

  always_comb begin
    scan_lvl = '0;
    scan_hit = 1'b0;
    for (int i = prqd_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
      if (eligible[i]) begin
        scan_lvl = prqd_pkg::LVL_W'(i);
        scan_hit = 1'b1;
      end
    end
  end

  assign same_ok = ({1'b0, cp_q} < prqd_pkg::LIM_W'(prqd_pkg::NUM_LEVELS)) && nonempty[cp_q];

  always_comb begin
    lvl_sel = scan_lvl;
    rej_sel = 1'b0;
    hit_sel = scan_hit;
    unique case (mode_q)
      prqd_pkg::MODE_ENQUEUE: begin
        lvl_sel = tprio_q;
        hit_sel = 1'b0;
        rej_sel = (total_queued >= prqd_pkg::CNT_W'(prqd_pkg::NUM_TASKS))
               || ({1'b0, tid_q} >= prqd_pkg::CNT_W'(prqd_pkg::NUM_TASKS))
               || ({1'b0, tprio_q} >= prqd_pkg::LIM_W'(prqd_pkg::NUM_LEVELS));
      end
      prqd_pkg::MODE_PICK_HIGHER: begin
        rej_sel = 1'b0;
      end
      prqd_pkg::MODE_PICK_SAME: begin
        lvl_sel = cp_q;
        rej_sel = !cv_q;
        hit_sel = same_ok;
      end
      prqd_pkg::MODE_PEND_RUN: begin
        rej_sel = !cv_q;
      end
      default: begin
        rej_sel = 1'b1;
      end
    endcase
  end

  assign stat.enq    = enq_q;
  assign stat.reject = rej_q;
  assign stat.hit    = hit_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q  <= mode;
      tid_q   <= task_id;
      tprio_q <= task_priority;
      cv_q    <= current_valid;
      cp_q    <= current_priority;
    end
    if (cmd.look) begin
      lvl_q   <= lvl_sel;
      enq_q   <= (mode_q == prqd_pkg::MODE_ENQUEUE);
      rej_q   <= rej_sel;
      hit_q   <= hit_sel;
      head_rd <= head_mem[lvl_sel];
      tail_rd <= tail_mem[lvl_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < prqd_pkg::NUM_LEVELS; i++) begin
        level_count[i] <= '0;
      end
      total_queued <= '0;
    end else if (cmd.enq) begin
      level_count[lvl_q] <= level_count[lvl_q] + 1'b1;
      total_queued       <= total_queued + 1'b1;
    end else if (cmd.pop) begin
      level_count[lvl_q] <= level_count[lvl_q] - 1'b1;
      if (total_queued != '0) total_queued <= total_queued - 1'b1;
    end
  end

  assign head_we = (cmd.enq && !nonempty[lvl_q]) || cmd.fix_head;
  assign head_wd = cmd.enq ? tid_q : link_rd;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[lvl_q] <= head_wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.enq) tail_mem[lvl_q] <= tid_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.enq && nonempty[lvl_q]) link_mem[tail_rd] <= tid_q;
    if (cmd.pop) link_rd <= link_mem[head_rd];
  end

  assign dispatched = !enq_q && !rej_q && hit_q;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (rej_q) begin
        status <= prqd_pkg::ST_REJECTED;
      end else if (enq_q) begin
        status <= prqd_pkg::ST_ENQUEUED;
      end else if (hit_q) begin
        status <= prqd_pkg::ST_DISPATCHED;
      end else begin
        status <= prqd_pkg::ST_NONE;
      end
      picked_task     <= dispatched ? head_rd : '0;
      picked_priority <= dispatched ? lvl_q : '0;
      switch_request  <= dispatched && (mode_q == prqd_pkg::MODE_PEND_RUN);
    end
  end

endmodule

`default_nettype wire

/* rtl/priority_ready_queue_dispatch.sv */
// Priority ready queue: one FIFO of task ids per priority level, level 0 best.
// Input channel (in_valid / in_stall) carries one scheduler call per item:
// mode 0 enqueues task_id at task_priority, mode 1 pops the best level above
// the running task (any level if none runs), mode 2 pops the running task's
// own level, mode 3 pops the best level and raises switch_request.
// Output channel (out_valid / out_stall) returns exactly one item per call:
// status, picked_task, picked_priority, switch_request.
// One call is in flight at a time: in_stall stays high from acceptance until
// the result is loaded. Each call runs the level scan with head and tail read,
// then the enqueue or pop (a pop reads the link memory), then for a dispatch
// the head write-back, then the load into the output register.
// The result sits in an output register: a stalled receiver holds it
// unchanged, and the block finishes the next call but keeps it until the
// register frees. Reset empties every level and drops any pending item;
// the block accepts items on the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module priority_ready_queue_dispatch (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  mode,
  input  wire logic [prqd_pkg::TASK_W-1:0] task_id,
  input  wire logic [prqd_pkg::LVL_W-1:0]  task_priority,
  input  wire logic                        current_valid,
  input  wire logic [prqd_pkg::LVL_W-1:0]  current_priority,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       status,
  output logic [prqd_pkg::TASK_W-1:0]      picked_task,
  output logic [prqd_pkg::LVL_W-1:0]       picked_priority,
  output logic                             switch_request
);

  prqd_pkg::cmd_t  cmd;
  prqd_pkg::stat_t stat;

  prqd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  prqd_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .mode             (mode),
    .task_id          (task_id),
    .task_priority    (task_priority),
    .current_valid    (current_valid),
    .current_priority (current_priority),
    .status           (status),
    .picked_task      (picked_task),
    .picked_priority  (picked_priority),
    .switch_request   (switch_request)
  );

endmodule

`default_nettype wire

/* rtl/prqd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module prqd_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic [1:0]                  mode,
  input wire logic [prqd_pkg::TASK_W-1:0] task_id,
  input wire logic [prqd_pkg::LVL_W-1:0]  task_priority,
  input wire logic                        current_valid,
  input wire logic [prqd_pkg::LVL_W-1:0]  current_priority,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [1:0]                  status,
  input wire logic [prqd_pkg::TASK_W-1:0] picked_task,
  input wire logic [prqd_pkg::LVL_W-1:0]  picked_priority,
  input wire logic                        switch_request
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(mode) && $stable(task_id)
      && $stable(task_priority) && $stable(current_valid) && $stable(current_priority))
    else $error("stalled input item changed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(picked_task)
      && $stable(picked_priority) && $stable(switch_request))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in flight");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != prqd_pkg::ST_DISPATCHED |-> picked_task == '0
      && picked_priority == '0 && !switch_request)
    else $error("pick fields set without a dispatch");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset did not clear the block");

endmodule

bind priority_ready_queue_dispatch prqd_checker u_prqd_checker (.*);

`default_nettype wire
